### hdl/oal_pkg.sv
// ----------------------------------------------------------------------------
// oal_pkg - shared types and constants for the ordered array list engine
// Field widths of the request and result channels, operation and status
// codes, and the command word broadcast to the row of list cells.
// ----------------------------------------------------------------------------
package oal_pkg;

  // Fixed field widths of the channels
  localparam int OP_W      = 3;
  localparam int IDX_W     = 4;
  localparam int VAL_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 5;
  localparam int CAP_W     = 5;

  // Width of position compares inside the cell row (covers positions and counts up to 511)
  localparam int POS_W = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_EDIT   = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4,
    OP_FIND   = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  // Broadcast to every cell: en marks a request that changes the list
  typedef struct packed {
    logic             en;
    op_t              op;
    logic [POS_W-1:0] idx;
    logic [POS_W-1:0] cnt;
  } cell_cmd_t;

endpackage

### hdl/oal_in_if.sv
// ----------------------------------------------------------------------------
// oal_in_if - request channel
// Valid/ready channel carrying one list operation per request.
// ----------------------------------------------------------------------------
interface oal_in_if;
  import oal_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] index;
  logic [VAL_W-1:0] data_value;

  modport source (output valid, operation, index, data_value, input ready);
  modport sink   (input valid, operation, index, data_value, output ready);
endinterface

### hdl/oal_out_if.sv
// ----------------------------------------------------------------------------
// oal_out_if - result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface oal_out_if;
  import oal_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [VAL_W-1:0]     read_value;
  logic                 found;
  logic [IDX_W-1:0]     found_index;
  logic [CNT_OUT_W-1:0] entry_count;
  logic                 is_empty;
  logic                 is_full;

  modport source (output valid, status, read_value, found, found_index,
                  entry_count, is_empty, is_full, input ready);
  modport sink   (input valid, status, read_value, found, found_index,
                  entry_count, is_empty, is_full, output ready);
endinterface

### hdl/oal_cfg_if.sv
// ----------------------------------------------------------------------------
// oal_cfg_if - configuration write channel
// Valid/ready channel writing the capacity register.
// ----------------------------------------------------------------------------
interface oal_cfg_if;
  import oal_pkg::*;

  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity_in_use;

  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface

### hdl/oal_cell.sv
// ----------------------------------------------------------------------------
// oal_cell - one list position
// Holds one entry, decides from the broadcast command whether to load the
// request word or take a neighbor's entry, and flags the first live match.
// ----------------------------------------------------------------------------
module oal_cell #(
  parameter int POS        = 0,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  oal_pkg::cell_cmd_t    cmd,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic [DATA_WIDTH-1:0] left_val,
  input  logic [DATA_WIDTH-1:0] right_val,
  input  logic                  prior_hit,
  output logic [DATA_WIDTH-1:0] val,
  output logic                  any_hit,
  output logic                  first_hit
);
  import oal_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

  logic [DATA_WIDTH-1:0] val_r;
  logic [DATA_WIDTH-1:0] val_nxt;
  logic                  live;
  logic                  hit;

  // Pick the next entry from the command
  always_comb begin
    val_nxt = val_r;
    if (cmd.en) begin
      case (cmd.op)
        OP_APPEND: begin
          if (MY_POS == cmd.cnt) val_nxt = key;
        end
        OP_INSERT: begin
          if (MY_POS == cmd.idx) val_nxt = key;
          else if (MY_POS > cmd.idx && MY_POS <= cmd.cnt) val_nxt = left_val;
        end
        OP_EDIT: begin
          if (MY_POS == cmd.idx) val_nxt = key;
        end
        OP_DELETE: begin
          if (MY_POS >= cmd.idx && (MY_POS + POS_W'(1)) < cmd.cnt) val_nxt = right_val;
        end
        default: begin
          val_nxt = val_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  // Match against the key, passing the hit chain on to the next cell
  assign live      = MY_POS < cmd.cnt;
  assign hit       = live && (val_r == key);
  assign first_hit = hit && !prior_hit;
  assign any_hit   = hit || prior_hit;
  assign val       = val_r;

endmodule

### hdl/ordered_array_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_array_list_engine - fixed-capacity ordered list of words
// Append, insert, edit, delete, read and find on a row of list cells that
// shift toward their neighbors; every request returns status and count.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+---------------------------------
//  in_ch    | in  | valid/ready          | operation, index, data_value
//  out_ch   | out | valid/ready          | status, read_value, found,
//           |     |                      | found_index, entry_count,
//           |     |                      | is_empty, is_full
//  cfg_ch   | in  | valid/ready (ready=1)| capacity_in_use
//
//  One request per cycle unless stalled; the cell row and the output register
//  both load at the accepting edge, so the result is valid in the next cycle.
//  Latency is set by the single output register; all cells shift in parallel.
//  Reset clears the count, the output valid and sets capacity to 16; the
//  entries themselves are not cleared.
//  in_ch stalls only while a result is held and out_ch.ready is low.
// ----------------------------------------------------------------------------
module ordered_array_list_engine #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  oal_in_if.sink    in_ch,
  oal_out_if.source out_ch,
  oal_cfg_if.sink   cfg_ch
);
  import oal_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic [CAP_W-1:0]     cap_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [VAL_W-1:0]     out_read_r;
  logic                 out_found_r;
  logic [IDX_W-1:0]     out_fidx_r;
  logic [CNT_OUT_W-1:0] out_count_r;
  logic                 out_empty_r;
  logic                 out_full_r;

  logic                  acc;
  logic [POS_W-1:0]      eff_cap;
  logic [POS_W-1:0]      cnt_ext;
  logic [POS_W-1:0]      idx_ext;
  logic [POS_W-1:0]      cnt_calc;
  logic                  full_pre;
  status_t               status_c;
  logic                  wr_c;
  logic [DATA_WIDTH-1:0] key;
  cell_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] cell_val [DEPTH];
  logic                  cell_first [DEPTH];
  logic                  hit_chain [DEPTH+1];
  logic [DATA_WIDTH-1:0] rd_sel;
  logic [POS_W-1:0]      fidx_sel;
  logic [63:0]           rd_wide;

  assign acc     = in_ch.valid && in_ch.ready;
  assign cnt_ext = POS_W'(count_r);
  assign idx_ext = POS_W'(in_ch.index);
  assign key     = DATA_WIDTH'(in_ch.data_value);

  // Clamp the capacity register to 1..DEPTH
  always_comb begin
    if (cap_r == '0) eff_cap = POS_W'(1);
    else if (POS_W'(cap_r) > POS_W'(DEPTH)) eff_cap = POS_W'(DEPTH);
    else eff_cap = POS_W'(cap_r);
  end

  assign full_pre = cnt_ext >= eff_cap;

  // Check the request and work out the new count
  always_comb begin
    status_c = ST_OK;
    wr_c     = 1'b0;
    cnt_calc = cnt_ext;
    case (in_ch.operation)
      OP_APPEND: begin
        if (full_pre) status_c = ST_OVERFLOW;
        else begin
          wr_c     = 1'b1;
          cnt_calc = cnt_ext + POS_W'(1);
        end
      end
      OP_INSERT: begin
        if (idx_ext > cnt_ext) status_c = ST_BAD_INDEX;
        else if (full_pre) status_c = ST_OVERFLOW;
        else begin
          wr_c     = 1'b1;
          cnt_calc = cnt_ext + POS_W'(1);
        end
      end
      OP_EDIT: begin
        if (idx_ext >= cnt_ext) status_c = ST_BAD_INDEX;
        else wr_c = 1'b1;
      end
      OP_DELETE: begin
        if (idx_ext >= cnt_ext) status_c = ST_BAD_INDEX;
        else begin
          wr_c     = 1'b1;
          cnt_calc = cnt_ext - POS_W'(1);
        end
      end
      OP_READ: begin
        if (idx_ext >= cnt_ext) status_c = ST_BAD_INDEX;
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  assign count_nxt = (acc && wr_c) ? CNT_W'(cnt_calc) : count_r;

  // Broadcast the request to the cell row
  assign cmd.en  = acc && wr_c;
  assign cmd.op  = op_t'(in_ch.operation);
  assign cmd.idx = idx_ext;
  assign cmd.cnt = cnt_ext;

  assign hit_chain[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    oal_cell #(
      .POS        (g),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .key       (key),
      .left_val  ((g == 0) ? '0 : cell_val[(g == 0) ? 0 : g - 1]),
      .right_val ((g == DEPTH - 1) ? '0 : cell_val[(g == DEPTH - 1) ? g : g + 1]),
      .prior_hit (hit_chain[g]),
      .val       (cell_val[g]),
      .any_hit   (hit_chain[g+1]),
      .first_hit (cell_first[g])
    );
  end

  // Gather the addressed entry and the first match position
  always_comb begin
    rd_sel   = '0;
    fidx_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (POS_W'(i) == idx_ext) rd_sel = rd_sel | cell_val[i];
      if (cell_first[i]) fidx_sel = fidx_sel | POS_W'(i);
    end
  end

  assign rd_wide = 64'(rd_sel);

  // Hold count and capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      count_r <= count_nxt;
      if (cfg_ch.valid && cfg_ch.ready) cap_r <= cfg_ch.capacity_in_use;
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Output register: advance on accept, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_status_r <= status_c;
      out_read_r   <= (in_ch.operation == OP_READ && status_c == ST_OK) ?
                      rd_wide[VAL_W-1:0] : '0;
      out_found_r  <= (in_ch.operation == OP_FIND) && hit_chain[DEPTH];
      out_fidx_r   <= (in_ch.operation == OP_FIND) ? fidx_sel[IDX_W-1:0] : '0;
      out_count_r  <= CNT_OUT_W'(cnt_calc);
      out_empty_r  <= cnt_calc == '0;
      out_full_r   <= cnt_calc >= eff_cap;
    end
  end

  assign in_ch.ready        = !out_valid_r || out_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.read_value  = out_read_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.found_index = out_fidx_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.is_empty    = out_empty_r;
  assign out_ch.is_full     = out_full_r;

  // Checks
  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.operation == OP_APPEND && !full_pre |=>
      count_r == $past(count_r) + CNT_W'(1))
    else $error("append did not grow the count");

  a_error_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc && status_c != ST_OK |=> $stable(count_r))
    else $error("rejected request changed the count");

  a_bad_read_reported: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.operation == OP_READ && idx_ext >= cnt_ext |=>
      out_valid_r && out_status_r == ST_BAD_INDEX && out_read_r == '0)
    else $error("read past the count not reported");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r && out_count_r == CNT_OUT_W'(count_r))
    else $error("result count does not match list count");

endmodule
